// ===== hw/rtl/crfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crfs_pkg
// Shared types and constants for the circle raster frame store.
// ----------------------------------------------------------------------------
package crfs_pkg;

  // Command codes carried on the kind field
  typedef enum logic [1:0] {
    KIND_PLOT   = 2'd0,
    KIND_CIRCLE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  localparam int COORD_W = 8;   // signed point coordinate, covers -128..127
  localparam int ERR_W   = 10;  // signed midpoint decision term
  localparam int OCT_W   = 3;   // octant counter

  localparam logic [7:0] RD_BIAS = 8'd127;

  // Controller to datapath
  typedef struct packed {
    logic load;        // latch command fields, restart accumulators
    logic plot_issue;  // send the plot point into the write stage
    logic circ_issue;  // send one octant point, step the circle after the eighth
    logic rd_issue;    // read the store at the command position
    logic rd_capture;  // form the read result
    logic clr_step;    // zero one entry, advance the sweep address
    logic res_push;    // load the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;    // sweep address is at the final entry
    logic circ_more;   // x >= y, circle loop continues
  } sts_t;

endpackage

// ===== hw/rtl/circle_raster_frame_store.sv =====
// Result word is registered in the output register when a command is done: plot
// goes S_PLOT, S_DRAIN, S_DONE; read goes S_READ, S_READ_WAIT, S_DONE; a circle
// writes eight octant points per loop pass (about 0.71 * radius + 1 passes);
// clear sweeps every entry; one command in flight at a time. The single frame store
// write port sets the circle rate, one point a cycle. Reset sweeps the store to zero
// with in_stall high and the output register empty.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_raster_frame_store
// RGB332 frame store with plot, midpoint circle, read and clear commands.
// ----------------------------------------------------------------------------
module circle_raster_frame_store
  import crfs_pkg::*;
#(
  parameter int FRAME_SIDE = 36
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] kind,
  input  logic [5:0] pos_x,
  input  logic [5:0] pos_y,
  input  logic [5:0] radius,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_value,
  output logic       clipped
);

  cmd_t       cmd;
  sts_t       sts;
  logic [7:0] res_value;
  logic       res_clip;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;

  crfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .out_free (out_free),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  crfs_datapath #(
    .FRAME_SIDE (FRAME_SIDE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .radius    (radius),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .sts       (sts),
    .res_value (res_value),
    .res_clip  (res_clip)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_push) begin
      read_value <= res_value;
      clipped    <= res_clip;
    end
  end

`ifndef ASSERT_OFF
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.res_push |-> (!out_valid || !out_stall))
    else $error("result pushed over a held word");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second word taken while a command is in flight");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.res_push))
    else $error("output word appeared without a finished command");
`endif

endmodule

// ===== hw/rtl/crfs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crfs_ctrl
// Command sequencer: decodes a word, steps the datapath, hands off the result.
// ----------------------------------------------------------------------------
module crfs_ctrl
  import crfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] kind,
  input  logic       out_free,
  input  sts_t       sts,
  output logic       in_stall,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PLOT,
    S_CIRCLE,
    S_READ,
    S_READ_WAIT,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   owed;        // clear sweep belongs to a command, not to reset
  logic   accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = owed ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          unique case (kind_t'(kind))
            KIND_PLOT:   state_next = S_PLOT;
            KIND_CIRCLE: state_next = S_CIRCLE;
            KIND_READ:   state_next = S_READ;
            KIND_CLEAR:  state_next = S_CLEAR;
          endcase
        end
      end
      S_PLOT: begin
        cmd.plot_issue = 1'b1;
        state_next     = S_DRAIN;
      end
      S_CIRCLE: begin
        // last point sits in the write stage when the loop test fails
        if (sts.circ_more) begin
          cmd.circ_issue = 1'b1;
        end else begin
          state_next = S_DONE;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_READ_WAIT;
      end
      S_READ_WAIT: begin
        cmd.rd_capture = 1'b1;
        state_next     = S_DONE;
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.res_push = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      owed  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        owed <= 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/crfs_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crfs_datapath
// Command registers, midpoint circle stepper, point write stage and the
// frame store memory with its clear sweep counter.
// ----------------------------------------------------------------------------
module crfs_datapath
  import crfs_pkg::*;
#(
  parameter int FRAME_SIDE = 36
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  logic [5:0] pos_x,
  input  logic [5:0] pos_y,
  input  logic [5:0] radius,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output sts_t       sts,
  output logic [7:0] res_value,
  output logic       res_clip
);

  localparam int DEPTH = FRAME_SIDE * FRAME_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [COORD_W-1:0] SIDE = COORD_W'(FRAME_SIDE);

  function automatic logic on_frame(input logic signed [COORD_W-1:0] px,
                                    input logic signed [COORD_W-1:0] py);
    on_frame = !px[COORD_W-1] && !py[COORD_W-1] &&
               (px < SIDE) && (py < SIDE);
  endfunction

  function automatic logic [AW-1:0] pix_addr(input logic [5:0] px,
                                             input logic [5:0] py);
    pix_addr = AW'(py) * AW'(FRAME_SIDE) + AW'(px);
  endfunction

  logic [7:0] mem [DEPTH];

  // command registers
  logic [5:0] pos_x_q;
  logic [5:0] pos_y_q;
  logic [7:0] colour;

  // circle state
  logic signed [COORD_W-1:0] cx;
  logic signed [COORD_W-1:0] cy;
  logic signed [ERR_W-1:0]   err;
  logic [OCT_W-1:0]          oct;

  // point write stage
  logic                      pt_vld;
  logic signed [COORD_W-1:0] pt_x;
  logic signed [COORD_W-1:0] pt_y;
  logic                      pt_on;

  logic [AW-1:0] clr_addr;
  logic [7:0]    rd_data;
  logic          rd_on;

  logic signed [COORD_W-1:0] ox;
  logic signed [COORD_W-1:0] oy;
  logic signed [COORD_W-1:0] sel_a;
  logic signed [COORD_W-1:0] sel_b;
  logic signed [COORD_W-1:0] dx;
  logic signed [COORD_W-1:0] dy;
  logic signed [COORD_W-1:0] base_x;
  logic signed [COORD_W-1:0] base_y;
  logic signed [COORD_W-1:0] y_inc;
  logic signed [COORD_W-1:0] x_dec;
  logic signed [ERR_W-1:0]   err_keep;
  logic signed [ERR_W-1:0]   err_move;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  assign base_x = $signed({2'b00, pos_x_q});
  assign base_y = $signed({2'b00, pos_y_q});

  // octant mapping: odd octants swap x and y, octants 2..5 mirror x, 4..7 mirror y
  always_comb begin
    sel_a = oct[0] ? cy : cx;
    sel_b = oct[0] ? cx : cy;
    dx    = (oct[2] ^ oct[1]) ? -sel_a : sel_a;
    dy    = oct[2] ? -sel_b : sel_b;
    if (cmd.plot_issue) begin
      ox = base_x;
      oy = base_y;
    end else begin
      ox = base_x + dx;
      oy = base_y + dy;
    end
  end

  // midpoint update, y advanced first
  assign y_inc    = cy + COORD_W'(1);
  assign x_dec    = cx - COORD_W'(1);
  assign err_keep = err + (ERR_W'(y_inc) <<< 1) + ERR_W'(1);
  assign err_move = err + ((ERR_W'(y_inc) - ERR_W'(x_dec) + ERR_W'(1)) <<< 1);

  assign sts.circ_more = (cx >= cy);
  assign sts.clr_last  = (clr_addr == LAST_ADDR);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_x_q <= pos_x;
      pos_y_q <= pos_y;
      colour  <= {red[7:5], green[7:5], blue[7:6]};
      cx      <= $signed({2'b00, radius});
      cy      <= '0;
      err     <= ERR_W'(1) - $signed(ERR_W'(radius));
      oct     <= '0;
    end else if (cmd.circ_issue) begin
      oct <= oct + OCT_W'(1);
      if (oct == '1) begin
        cy <= y_inc;
        if (err[ERR_W-1]) begin
          err <= err_keep;
        end else begin
          cx  <= x_dec;
          err <= err_move;
        end
      end
    end
    pt_x <= ox;
    pt_y <= oy;
  end

  assign pt_on = on_frame(pt_x, pt_y);
  assign rd_on = on_frame(base_x, base_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_vld   <= 1'b0;
      clr_addr <= '0;
    end else begin
      pt_vld <= cmd.plot_issue || cmd.circ_issue;
      if (cmd.load) begin
        clr_addr <= '0;
      end else if (cmd.clr_step) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // result accumulators
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_clip  <= 1'b0;
      res_value <= '0;
    end else begin
      if (pt_vld && !pt_on) begin
        res_clip <= 1'b1;
      end
      if (cmd.rd_capture) begin
        if (rd_on) begin
          res_value <= rd_data + RD_BIAS;
        end else begin
          res_clip <= 1'b1;
        end
      end
    end
  end

  // single write port shared by the clear sweep and the point stage
  assign wr_en   = cmd.clr_step || (pt_vld && pt_on);
  assign wr_addr = cmd.clr_step ? clr_addr : pix_addr(pt_x[5:0], pt_y[5:0]);
  assign wr_data = cmd.clr_step ? 8'd0 : colour;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue && rd_on) begin
      rd_data <= mem[pix_addr(pos_x_q, pos_y_q)];
    end
  end

endmodule
